[rtl/dlps_pkg.sv]
package dlps_pkg;

    // Frame and coordinate geometry
    localparam int COORD_BITS      = 12;
    localparam int FRAME_WIDTH     = 640;
    localparam int FRAME_HEIGHT    = 480;
    localparam int FRAC_BITS       = 16;
    localparam int ACC_W           = 32;
    localparam int BYTES_PER_PIXEL = 3;

    // Register and field widths
    localparam int PITCH_W    = 13;
    localparam int COLOR_W    = 8;
    localparam int ADDR_OUT_W = 22;
    localparam int PROD_W     = PITCH_W + 1 + COORD_BITS;
    localparam int PX3_W      = COORD_BITS + 2;
    localparam int ADDR_W     = PROD_W + 1;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(1920);

    // Input stream layout
    localparam int XS_LSB     = 0;
    localparam int YS_LSB     = COORD_BITS;
    localparam int XE_LSB     = 2 * COORD_BITS;
    localparam int YE_LSB     = 3 * COORD_BITS;
    localparam int IN_DATA_W  = 4 * COORD_BITS;
    localparam int S_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;

    // Output stream layout
    localparam int PX_LSB     = 0;
    localparam int PY_LSB     = COORD_BITS;
    localparam int BA_LSB     = 2 * COORD_BITS;
    localparam int BLUE_LSB   = BA_LSB + ADDR_OUT_W;
    localparam int GREEN_LSB  = BLUE_LSB + COLOR_W;
    localparam int RED_LSB    = GREEN_LSB + COLOR_W;
    localparam int OUT_DATA_W = RED_LSB + COLOR_W;
    localparam int M_TDATA_W  = ((OUT_DATA_W + 7) / 8) * 8;

    // Register port
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [1:0] REG_ROW_PITCH   = 2'd0;
    localparam logic [1:0] REG_COLOR_RED   = 2'd1;
    localparam logic [1:0] REG_COLOR_GREEN = 2'd2;
    localparam logic [1:0] REG_COLOR_BLUE  = 2'd3;

    // Request kinds carried on tuser
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ORDER,
        ST_DIV,
        ST_STEP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] dividend;
        logic [COORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/dda_line_pixel_stepper_top.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser = req_type; s_tdata = endpoints
// m_*       out  m_tvalid/m_tready  m_tdata = pixel; m_tuser = in_frame; m_tlast
// APB       in   psel/penable       row_pitch, color_red, color_green, color_blue
//
// A step item passes through accept, address multiply, and address add and
// range check into the output register. A start item with distinct endpoints
// waits on the restoring divider, which produces one of 17 quotient bits
// per cycle. The block takes no item while a start or a step is in work.
// A result held by a stalled m_tready stays in the output register; the next
// step may be accepted meanwhile and waits in the emit state until it frees.
// Reset is synchronous and active low; no line is active after reset.
module dda_line_pixel_stepper_top
    import dlps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [11:0] x_start, [23:12] y_start, [35:24] x_end, [47:36] y_end
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] req_type
    input  logic                 s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [11:0] pixel_x, [23:12] pixel_y, [45:24] byte_address,
    // [53:46] out_blue, [61:54] out_green, [69:62] out_red, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] in_frame
    output logic                 m_tuser,
    output logic                 m_tlast,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // ---------------- configuration registers ----------------
    logic [PITCH_W-1:0] row_pitch_reg;
    logic [COLOR_W-1:0] color_red_reg;
    logic [COLOR_W-1:0] color_green_reg;
    logic [COLOR_W-1:0] color_blue_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pitch_reg   <= PITCH_RESET;
            color_red_reg   <= '0;
            color_green_reg <= '0;
            color_blue_reg  <= '0;
        end else if (cfg_wr) begin
            case (paddr[PADDR_W-1:2])
                REG_ROW_PITCH:   row_pitch_reg   <= pwdata[PITCH_W-1:0];
                REG_COLOR_RED:   color_red_reg   <= pwdata[COLOR_W-1:0];
                REG_COLOR_GREEN: color_green_reg <= pwdata[COLOR_W-1:0];
                REG_COLOR_BLUE:  color_blue_reg  <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1:2])
            REG_ROW_PITCH:   prdata = PDATA_W'(row_pitch_reg);
            REG_COLOR_RED:   prdata = PDATA_W'(color_red_reg);
            REG_COLOR_GREEN: prdata = PDATA_W'(color_green_reg);
            REG_COLOR_BLUE:  prdata = PDATA_W'(color_blue_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    state_t state_reg;
    state_t state_next;

    logic s_acc;
    logic is_start;
    logic same_ends;
    logic out_free;
    logic ep_load;
    logic order_en;
    logic div_take;
    logic step_en;
    logic out_load;

    logic line_active_reg;
    logic m_tvalid_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign s_acc     = s_tvalid && s_tready;
    assign is_start  = s_tuser == REQ_START;
    // Identical endpoints load no line
    assign same_ends = (s_tdata[XS_LSB +: COORD_BITS] == s_tdata[XE_LSB +: COORD_BITS])
                    && (s_tdata[YS_LSB +: COORD_BITS] == s_tdata[YE_LSB +: COORD_BITS]);
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (is_start) begin
                        state_next = same_ends ? ST_IDLE : ST_SETUP;
                    end else begin
                        state_next = line_active_reg ? ST_STEP : ST_IDLE;
                    end
                end
            end
            ST_SETUP: state_next = ST_ORDER;
            ST_ORDER: state_next = ST_DIV;
            ST_DIV:   state_next = div_rsp.done ? ST_IDLE : ST_DIV;
            ST_STEP:  state_next = ST_EMIT;
            ST_EMIT:  state_next = out_free ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        ep_load  = 1'b0;
        order_en = 1'b0;
        div_take = 1'b0;
        step_en  = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                ep_load  = s_tvalid && is_start;
            end
            ST_SETUP: ;
            ST_ORDER: order_en = 1'b1;
            ST_DIV:   div_take = div_rsp.done;
            ST_STEP:  step_en  = 1'b1;
            ST_EMIT:  out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- line set-up ----------------
    logic signed [COORD_BITS-1:0] x1_reg;
    logic signed [COORD_BITS-1:0] y1_reg;
    logic signed [COORD_BITS-1:0] x2_reg;
    logic signed [COORD_BITS-1:0] y2_reg;

    always_ff @(posedge aclk) begin
        if (ep_load) begin
            x1_reg <= s_tdata[XS_LSB +: COORD_BITS];
            y1_reg <= s_tdata[YS_LSB +: COORD_BITS];
            x2_reg <= s_tdata[XE_LSB +: COORD_BITS];
            y2_reg <= s_tdata[YE_LSB +: COORD_BITS];
        end
    end

    // Steep when the row span exceeds the column span
    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic        [COORD_BITS:0] adx;
    logic        [COORD_BITS:0] ady;
    logic                       steep_reg;
    logic                       steep_next;

    assign dx         = $signed({x2_reg[COORD_BITS-1], x2_reg})
                      - $signed({x1_reg[COORD_BITS-1], x1_reg});
    assign dy         = $signed({y2_reg[COORD_BITS-1], y2_reg})
                      - $signed({y1_reg[COORD_BITS-1], y1_reg});
    assign adx        = dx[COORD_BITS] ? unsigned'(-dx) : unsigned'(dx);
    assign ady        = dy[COORD_BITS] ? unsigned'(-dy) : unsigned'(dy);
    assign steep_next = ady > adx;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SETUP) begin
            steep_reg <= steep_next;
        end
    end

    // Order the endpoints along the major axis
    logic signed [COORD_BITS-1:0] maj1;
    logic signed [COORD_BITS-1:0] maj2;
    logic signed [COORD_BITS-1:0] min1;
    logic signed [COORD_BITS-1:0] min2;
    logic                         swap;
    logic signed [COORD_BITS-1:0] maj_start;
    logic signed [COORD_BITS-1:0] maj_stop;
    logic signed [COORD_BITS-1:0] min_start;
    logic signed [COORD_BITS-1:0] min_stop;
    logic        [COORD_BITS:0]   dmaj;
    logic signed [COORD_BITS:0]   dmin;
    logic        [COORD_BITS:0]   admin;
    logic                         neg_reg;

    assign maj1      = steep_reg ? y1_reg : x1_reg;
    assign maj2      = steep_reg ? y2_reg : x2_reg;
    assign min1      = steep_reg ? x1_reg : y1_reg;
    assign min2      = steep_reg ? x2_reg : y2_reg;
    assign swap      = maj1 > maj2;
    assign maj_start = swap ? maj2 : maj1;
    assign maj_stop  = swap ? maj1 : maj2;
    assign min_start = swap ? min2 : min1;
    assign min_stop  = swap ? min1 : min2;
    assign dmaj      = unsigned'($signed({maj_stop[COORD_BITS-1], maj_stop})
                     - $signed({maj_start[COORD_BITS-1], maj_start}));
    assign dmin      = $signed({min_stop[COORD_BITS-1], min_stop})
                     - $signed({min_start[COORD_BITS-1], min_start});
    assign admin     = dmin[COORD_BITS] ? unsigned'(-dmin) : unsigned'(dmin);

    assign div_req.start    = order_en;
    assign div_req.dividend = admin[COORD_BITS-1:0];
    assign div_req.divisor  = dmaj[COORD_BITS-1:0];

    dlps_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- stepping state ----------------
    logic signed [COORD_BITS-1:0] major_pos_reg;
    logic signed [COORD_BITS-1:0] major_end_reg;
    logic        [ACC_W-1:0]      acc_reg;
    logic        [ACC_W-1:0]      inc_reg;
    logic        [ACC_W-1:0]      quo_ext;
    logic signed [COORD_BITS-1:0] minor;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic                         last;

    assign quo_ext = ACC_W'(div_rsp.quotient);
    assign minor   = acc_reg[FRAC_BITS +: COORD_BITS];
    assign px      = steep_reg ? minor : major_pos_reg;
    assign py      = steep_reg ? major_pos_reg : minor;
    assign last    = major_pos_reg >= major_end_reg;

    always_ff @(posedge aclk) begin
        if (order_en) begin
            major_pos_reg <= maj_start;
            major_end_reg <= maj_stop;
            acc_reg       <= ACC_W'(min_start) << FRAC_BITS;
            neg_reg       <= dmin[COORD_BITS];
        end else if (step_en && !last) begin
            major_pos_reg <= major_pos_reg + 1'b1;
            acc_reg       <= acc_reg + inc_reg;
        end
        if (div_take) begin
            inc_reg <= neg_reg ? -quo_ext : quo_ext;
        end
    end

    // Start drops any line in work; the divider result arms the new one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
        end else if (s_acc && is_start) begin
            line_active_reg <= 1'b0;
        end else if (div_take) begin
            line_active_reg <= 1'b1;
        end else if (step_en && last) begin
            line_active_reg <= 1'b0;
        end
    end

    // ---------------- pixel address and output ----------------
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic                         last_reg;
    logic        [ADDR_OUT_W-1:0] byte_address;
    logic                         in_frame;

    dlps_addr u_addr (
        .aclk         (aclk),
        .load         (step_en),
        .pitch        (row_pitch_reg),
        .px           (px),
        .py           (py),
        .byte_address (byte_address),
        .in_frame     (in_frame)
    );

    always_ff @(posedge aclk) begin
        if (step_en) begin
            px_reg   <= px;
            py_reg   <= py;
            last_reg <= last;
        end
    end

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({color_red_reg, color_green_reg, color_blue_reg,
                                       byte_address, py_reg, px_reg});
            m_tuser_reg <= in_frame;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/dlps_divider.sv]
// Restoring divider, one quotient bit per cycle.
// Computes (dividend << FRAC_BITS) / divisor for dividend <= divisor.
module dlps_divider
    import dlps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [COORD_BITS-1:0] rem_reg;
    logic [COORD_BITS-1:0] divisor_reg;
    logic [QUO_W-1:0]      shin_reg;
    logic [QUO_W-1:0]      quo_reg;

    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;
    logic [COORD_BITS-1:0] rem_next;
    logic                  last_step;

    assign trial     = {rem_reg, shin_reg[QUO_W-1]};
    assign diff      = trial - {1'b0, divisor_reg};
    assign ge        = trial >= {1'b0, divisor_reg};
    assign rem_next  = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    assign last_step = cnt_reg == DIV_CNT_W'(QUO_W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Seed with dividend >> 1 and shift its low bit in first, then zeros
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= req.dividend >> 1;
            shin_reg    <= {req.dividend[0], {FRAC_BITS{1'b0}}};
            divisor_reg <= req.divisor;
            quo_reg     <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            shin_reg <= shin_reg << 1;
            quo_reg  <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/dlps_addr.sv]
// Frame-buffer address unit: multiply stage, then add and range check.
module dlps_addr
    import dlps_pkg::*;
(
    input  logic                         aclk,
    input  logic                         load,
    input  logic        [PITCH_W-1:0]    pitch,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output logic        [ADDR_OUT_W-1:0] byte_address,
    output logic                         in_frame
);

    logic        [ADDR_W-1:0] limit_reg;
    logic        [ADDR_W-1:0] limit_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PX3_W-1:0]  px3_reg;
    logic signed [ADDR_W-1:0] addr;

    // Highest address inside the frame, follows the pitch register
    assign limit_next = ADDR_W'(pitch) * ADDR_W'(FRAME_HEIGHT - 1)
                      + ADDR_W'(BYTES_PER_PIXEL * (FRAME_WIDTH - 1));

    always_ff @(posedge aclk) begin
        limit_reg <= limit_next;
        if (load) begin
            prod_reg <= $signed({1'b0, pitch}) * py;
            px3_reg  <= PX3_W'(px) * PX3_W'(BYTES_PER_PIXEL);
        end
    end

    assign addr         = ADDR_W'(prod_reg) + ADDR_W'(px3_reg);
    assign byte_address = addr[ADDR_OUT_W-1:0];
    assign in_frame     = !addr[ADDR_W-1] && (unsigned'(addr) <= limit_reg);

endmodule

[rtl/dlps_checker.sv]
module dlps_checker
    import dlps_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    logic s_acc;
    logic start_line;

    assign s_acc      = s_tvalid && s_tready;
    assign start_line = s_acc && (s_tuser == REQ_START)
        && ((s_tdata[XS_LSB +: COORD_BITS] != s_tdata[XE_LSB +: COORD_BITS])
         || (s_tdata[YS_LSB +: COORD_BITS] != s_tdata[YE_LSB +: COORD_BITS]));

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // A real line start keeps the input closed while the step is computed
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_line |=> !s_tready)
        else $error("input open right after line start");

    // A pixel never appears the cycle after an item was taken
    a_no_early_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_acc))
        else $error("pixel appeared one cycle after accept");

endmodule

bind dda_line_pixel_stepper_top dlps_checker u_dlps_checker (.*);

[bench/tb_dda_line_pixel_stepper_top.sv]
`timescale 1ns / 1ps

module tb_dda_line_pixel_stepper_top;
    import dlps_pkg::*;

    // End the run if nothing moves for this many cycles. The slowest correct
    // stretch is a start, a sender gap, a long receiver stall and the settle
    // pause, all well below this.
    localparam int QUIET_LIMIT   = 3000;
    // Cycles to let a start finish its division once no pixel is owed.
    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 325;
    localparam int COORD_MAX     = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_MIN     = -(2 ** (COORD_BITS - 1));

    // One pixel as it leaves the block.
    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [ADDR_OUT_W-1:0] addr;
        logic                  in_frame;
        logic [COLOR_W-1:0]    blue;
        logic [COLOR_W-1:0]    green;
        logic [COLOR_W-1:0]    red;
        logic                  last;
    } pixel_t;

    // One row of the directed table; typed rows carry their pixel spelled out.
    typedef struct packed {
        logic                 req;
        logic [S_TDATA_W-1:0] data;
        logic                 typed;
        pixel_t               want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    dda_line_pixel_stepper_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    // Line walker state and register copies, kept in step with the block.
    logic                 line_on;
    logic                 steep_on;
    longint               lead_pos;
    longint               lead_end;
    logic [ACC_W-1:0]     minor_acc;
    logic [ACC_W-1:0]     minor_step;
    logic [PITCH_W-1:0]   pitch_reg;
    logic [COLOR_W-1:0]   red_reg;
    logic [COLOR_W-1:0]   green_reg;
    logic [COLOR_W-1:0]   blue_reg;

    pixel_t    pending_pixels[$];
    stim_row_t directed_rows[$];

    int  items_done     = 0;
    int  pixels_checked = 0;
    int  mismatches     = 0;
    int  burst_left     = 0;
    int  quiet_cycles   = 0;
    int  ready_mode     = 0;
    int  ready_left     = 0;
    bit  sender_steady  = 1'b0;

    // Walk the line one request further: a start loads a new line, a step
    // gives the next pixel while a line is active.
    function automatic void dda_apply(input logic req, input logic [S_TDATA_W-1:0] data,
                                      output bit emits, output pixel_t pix);
        logic signed [COORD_BITS-1:0] c0, c1, c2, c3;
        logic signed [ACC_W-1:0]      acc_s;
        longint ua, va, ub, vb, t, du, dv, wide, minor, px, py, addr, limit, pitch_l;
        emits = 1'b0;
        pix   = '0;
        if (req == REQ_START) begin
            c0 = data[XS_LSB +: COORD_BITS];
            c1 = data[YS_LSB +: COORD_BITS];
            c2 = data[XE_LSB +: COORD_BITS];
            c3 = data[YE_LSB +: COORD_BITS];
            ua = c0;
            va = c1;
            ub = c2;
            vb = c3;
            // A single point is no line; drop whatever was running.
            if (ua == ub && va == vb) begin
                line_on = 1'b0;
                return;
            end
            if (ua > ub) begin
                t = ua; ua = ub; ub = t;
                t = va; va = vb; vb = t;
            end
            du = ub - ua;
            dv = vb - va;
            steep_on = du < ((dv < 0) ? -dv : dv);
            if (steep_on) begin
                t = ua; ua = va; va = t;
                t = ub; ub = vb; vb = t;
                if (ua > ub) begin
                    t = ua; ua = ub; ub = t;
                    t = va; va = vb; vb = t;
                end
                du = ub - ua;
                dv = vb - va;
            end
            lead_pos   = ua;
            lead_end   = ub;
            wide       = va * 65536;
            minor_acc  = wide[ACC_W-1:0];
            // Signed division truncates toward zero, as the slope must.
            wide       = (dv * 65536) / du;
            minor_step = wide[ACC_W-1:0];
            line_on    = 1'b1;
            return;
        end
        if (!line_on) return;
        acc_s   = minor_acc;
        minor   = acc_s >>> FRAC_BITS;
        px      = steep_on ? minor : lead_pos;
        py      = steep_on ? lead_pos : minor;
        pitch_l = pitch_reg;
        addr    = pitch_l * py + BYTES_PER_PIXEL * px;
        limit   = pitch_l * (FRAME_HEIGHT - 1) + BYTES_PER_PIXEL * (FRAME_WIDTH - 1);
        pix.px       = px[COORD_BITS-1:0];
        pix.py       = py[COORD_BITS-1:0];
        pix.addr     = addr[ADDR_OUT_W-1:0];
        pix.in_frame = (addr >= 0) && (addr <= limit);
        pix.blue     = blue_reg;
        pix.green    = green_reg;
        pix.red      = red_reg;
        pix.last     = lead_pos >= lead_end;
        emits        = 1'b1;
        if (pix.last) begin
            line_on = 1'b0;
        end else begin
            lead_pos  = lead_pos + 1;
            minor_acc = minor_acc + minor_step;
        end
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_ends(input int xs, ys, xe, ye);
        logic [S_TDATA_W-1:0] p;
        p = '0;
        p[XS_LSB +: COORD_BITS] = xs[COORD_BITS-1:0];
        p[YS_LSB +: COORD_BITS] = ys[COORD_BITS-1:0];
        p[XE_LSB +: COORD_BITS] = xe[COORD_BITS-1:0];
        p[YE_LSB +: COORD_BITS] = ye[COORD_BITS-1:0];
        return p;
    endfunction

    function automatic logic [S_TDATA_W-1:0] rand_word();
        logic [S_TDATA_W-1:0] w;
        w = {$urandom, $urandom};
        return w;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    function automatic stim_row_t start_row(input int xs, ys, xe, ye);
        stim_row_t r;
        r      = '0;
        r.req  = REQ_START;
        r.data = pack_ends(xs, ys, xe, ye);
        return r;
    endfunction

    function automatic stim_row_t step_row();
        stim_row_t r;
        r     = '0;
        r.req = REQ_STEP;
        return r;
    endfunction

    // Typed pixel rows run under reset registers, so every colour is zero.
    function automatic stim_row_t pixel_row(input int px, py, addr, input logic inf, last);
        stim_row_t r;
        r               = step_row();
        r.typed         = 1'b1;
        r.want.px       = px[COORD_BITS-1:0];
        r.want.py       = py[COORD_BITS-1:0];
        r.want.addr     = addr[ADDR_OUT_W-1:0];
        r.want.in_frame = inf;
        r.want.last     = last;
        return r;
    endfunction

    // Offer one item in bursts with random gaps; on acceptance advance the
    // line walker and queue the pixel it owes.
    task automatic send_item(input logic req, input logic [S_TDATA_W-1:0] data,
                             input logic typed, input pixel_t typed_pix);
        int     gap;
        bit     emits;
        bit     ignored;
        pixel_t pix;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        ignored = (req == REQ_STEP) && !line_on;
        dda_apply(req, data, emits, pix);
        if (emits) pending_pixels.push_back(typed ? typed_pix : pix);
        if (!ignored) items_done++;
    endtask

    // A well-formed line with random content: mostly short spans, now and
    // then a long one, sometimes cut off early or stepped past its end.
    task automatic draw_line();
        int x0, y0, x1, y1, span, cap, n;
        if ($urandom_range(0, 1) == 0) begin
            x0 = $urandom_range(0, FRAME_WIDTH - 1);
            y0 = $urandom_range(0, FRAME_HEIGHT - 1);
        end else begin
            x0 = rand_coord();
            y0 = rand_coord();
        end
        span = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200) : $urandom_range(0, 12);
        x1 = x0 + int'($urandom_range(0, 2 * span)) - span;
        y1 = y0 + int'($urandom_range(0, 2 * span)) - span;
        if (x1 > COORD_MAX) x1 = COORD_MAX;
        if (x1 < COORD_MIN) x1 = COORD_MIN;
        if (y1 > COORD_MAX) y1 = COORD_MAX;
        if (y1 < COORD_MIN) y1 = COORD_MIN;
        send_item(REQ_START, pack_ends(x0, y0, x1, y1), 1'b0, '0);
        cap = ($urandom_range(0, 9) == 0) ? $urandom_range(0, span) : 1 << 20;
        n   = 0;
        while (line_on && n < cap) begin
            send_item(REQ_STEP, rand_word(), 1'b0, '0);
            n++;
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) send_item(REQ_STEP, rand_word(), 1'b0, '0);
    endtask

    // Write one register through the setup and access phases and mirror it.
    task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_ROW_PITCH:   pitch_reg = value[PITCH_W-1:0];
            REG_COLOR_RED:   red_reg   = value[COLOR_W-1:0];
            REG_COLOR_GREEN: green_reg = value[COLOR_W-1:0];
            REG_COLOR_BLUE:  blue_reg  = value[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    // Drop valid, wait until every owed pixel is out, then let a pending
    // start finish its division before anything touches the registers.
    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic report_pixel(input string what, input pixel_t want, input pixel_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s at %0t: exp x=%0d y=%0d addr=%h in=%b b/g/r=%h/%h/%h last=%b | got x=%0d y=%0d addr=%h in=%b b/g/r=%h/%h/%h last=%b",
                     what, $time,
                     $signed(want.px), $signed(want.py), want.addr, want.in_frame,
                     want.blue, want.green, want.red, want.last,
                     $signed(got.px), $signed(got.py), got.addr, got.in_frame,
                     got.blue, got.green, got.red, got.last);
    endtask

    // Receiver: switch between always ready, coin-flip ready and long stalls.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(32, 200);
        end
        ready_left--;
        case (ready_mode)
            0:       m_tready = 1'b1;
            1:       m_tready = $urandom_range(0, 1);
            default: m_tready = ($urandom_range(0, 5) == 0);
        endcase
    end

    // Check each accepted pixel against the oldest one owed.
    always @(posedge aclk) begin : pixel_check
        pixel_t got;
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.px       = m_tdata[PX_LSB +: COORD_BITS];
            got.py       = m_tdata[PY_LSB +: COORD_BITS];
            got.addr     = m_tdata[BA_LSB +: ADDR_OUT_W];
            got.blue     = m_tdata[BLUE_LSB +: COLOR_W];
            got.green    = m_tdata[GREEN_LSB +: COLOR_W];
            got.red      = m_tdata[RED_LSB +: COLOR_W];
            got.in_frame = m_tuser;
            got.last     = m_tlast;
            pixels_checked++;
            if (pending_pixels.size() == 0) begin
                report_pixel("unexpected pixel", '0, got);
            end else begin
                want = pending_pixels.pop_front();
                if (got.px !== want.px || got.py !== want.py || got.addr !== want.addr ||
                    got.in_frame !== want.in_frame || got.blue !== want.blue ||
                    got.green !== want.green || got.red !== want.red ||
                    got.last !== want.last)
                    report_pixel("pixel mismatch", want, got);
            end
        end
    end

    // Watchdog: count cycles in which no item, pixel or register write moves.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d pixels still owed",
                     quiet_cycles, pending_pixels.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [PDATA_W-1:0] pitch_v;
        logic [PDATA_W-1:0] red_v;
        logic [PDATA_W-1:0] green_v;
        logic [PDATA_W-1:0] blue_v;
        int                 phase_base;
        int                 pick;
        stim_row_t          row;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // Mirror the reset state of the block.
        line_on    = 1'b0;
        steep_on   = 1'b0;
        lead_pos   = 0;
        lead_end   = 0;
        minor_acc  = '0;
        minor_step = '0;
        pitch_reg  = PITCH_RESET;
        red_reg    = '0;
        green_reg  = '0;
        blue_reg   = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table, run under reset registers (pitch 1920, black).
        // Step right after reset, then a single-point line: no pixel either way.
        directed_rows.push_back(step_row());
        directed_rows.push_back(start_row(0, 0, 0, 0));
        directed_rows.push_back(step_row());
        // Short horizontal line from the origin, then one step past its end.
        directed_rows.push_back(start_row(0, 0, 3, 0));
        directed_rows.push_back(pixel_row(0, 0, 0, 1'b1, 1'b0));
        directed_rows.push_back(pixel_row(1, 0, 3, 1'b1, 1'b0));
        directed_rows.push_back(pixel_row(2, 0, 6, 1'b1, 1'b0));
        directed_rows.push_back(pixel_row(3, 0, 9, 1'b1, 1'b1));
        directed_rows.push_back(step_row());
        // Reversed endpoints, left unfinished so the next start replaces it.
        directed_rows.push_back(start_row(5, 10, 2, 10));
        directed_rows.push_back(step_row());
        directed_rows.push_back(step_row());
        // Corner to corner of the coordinate range, falling slope.
        directed_rows.push_back(start_row(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
        directed_rows.push_back(pixel_row(COORD_MIN, COORD_MAX, 3924096, 1'b0, 1'b0));
        directed_rows.push_back(step_row());
        // Steep two-pixel line ending exactly on the frame limit.
        directed_rows.push_back(start_row(639, 479, 639, 478));
        directed_rows.push_back(pixel_row(639, 478, 919677, 1'b1, 1'b0));
        directed_rows.push_back(pixel_row(639, 479, 921597, 1'b1, 1'b1));
        // Negative address: clipped, low bits still carried.
        directed_rows.push_back(start_row(-1, 0, 0, 0));
        directed_rows.push_back(pixel_row(-1, 0, 'h3FFFFD, 1'b0, 1'b0));
        directed_rows.push_back(pixel_row(0, 0, 0, 1'b1, 1'b1));
        // Steep line with a negative slope crossing zero.
        directed_rows.push_back(start_row(3, -2, 1, 2));
        directed_rows.push_back(step_row());
        directed_rows.push_back(step_row());
        directed_rows.push_back(step_row());

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_item(row.req, row.data, row.typed, row.want);
        end
        settle_idle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < RAND_PHASES; p++) begin
            red_v   = $urandom_range(0, 255);
            green_v = $urandom_range(0, 255);
            blue_v  = $urandom_range(0, 255);
            case (p)
                0: pitch_v = 1920;
                1: begin
                    pitch_v = 0;
                    red_v   = 0;
                    green_v = 0;
                    blue_v  = 0;
                end
                2: begin
                    pitch_v = 8191;
                    red_v   = 255;
                    green_v = 255;
                    blue_v  = 255;
                end
                3: pitch_v = 2560;
                4: pitch_v = $urandom_range(0, 8191);
                default: begin
                    pitch_v = 1;
                    red_v   = 255;
                    green_v = 0;
                end
            endcase
            apb_write(REG_ROW_PITCH, pitch_v);
            apb_write(REG_COLOR_RED, red_v);
            apb_write(REG_COLOR_GREEN, green_v);
            apb_write(REG_COLOR_BLUE, blue_v);

            // Hold the sender to back-to-back items for one phase.
            sender_steady = (p == 2);
            burst_left    = 0;
            phase_base    = items_done;
            while (items_done - phase_base < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    draw_line();
                end else if (pick < 86) begin
                    // Full-range endpoints, stepped only a little.
                    send_item(REQ_START, rand_word(), 1'b0, '0);
                    repeat ($urandom_range(0, 5)) send_item(REQ_STEP, rand_word(), 1'b0, '0);
                end else if (pick < 94) begin
                    send_item(REQ_STEP, rand_word(), 1'b0, '0);
                end else begin
                    pitch_v = rand_coord();
                    red_v   = rand_coord();
                    send_item(REQ_START, pack_ends(pitch_v, red_v, pitch_v, red_v), 1'b0, '0);
                end
            end
            settle_idle();
        end

        if (pending_pixels.size() != 0) begin
            mismatches += pending_pixels.size();
            $display("%0d pixels never came out", pending_pixels.size());
        end
        $display("covered %0d items (directed table plus %0d register settings), %0d pixels checked",
                 items_done, RAND_PHASES, pixels_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
